// ----- rtl/cbe_pkg.sv -----
// Shared types, constants and register indexes for the cubic Bezier evaluator.
package cbe_pkg;

   localparam int NUM_REGS               = 8;
   localparam int CSR_INDEX_WIDTH        = 3;
   localparam int LENGTH_SAMPLES_DEFAULT = 24;
   localparam int T_ONE                  = 65536;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CTRL_A_X = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CTRL_A_Y = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CTRL_B_X = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CTRL_B_Y = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_X = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_Y = 3'd7;

   localparam logic ACTION_EVAL   = 1'b0;
   localparam logic ACTION_LENGTH = 1'b1;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      logic        action;
      logic [16:0] t_param;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [35:0] slope_x;
      logic signed [35:0] slope_y;
      logic        [37:0] arc_length;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [16:0] t;
   } issue_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } sample_type;

   typedef enum logic [2:0] {
      LEN_IDLE,
      LEN_ISSUE,
      LEN_WAIT,
      LEN_SQUARE,
      LEN_SUM,
      LEN_ROOT,
      LEN_ACCUM,
      LEN_DONE
   } len_state_type;

endpackage

// ----- rtl/cbe_point_pipe.sv -----
// Bernstein pipeline: point and derivative, one t per cycle while en is set.
module cbe_point_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic                in_tag,
   input  logic [16:0]         in_t,
   input  cbe_pkg::coord_type  coord [cbe_pkg::NUM_REGS],
   output logic                out_valid,
   output logic                out_tag,
   output logic signed [31:0]  out_x,
   output logic signed [31:0]  out_y,
   output logic signed [35:0]  out_sx,
   output logic signed [35:0]  out_sy
);
   import cbe_pkg::*;

   // stage 0: t
   logic        s0_valid_ff, s0_tag_ff;
   logic [16:0] s0_t_ff;
   // stage 1: squares
   logic        s1_valid_ff, s1_tag_ff;
   logic [16:0] s1_u_ff, s1_t_ff;
   logic [32:0] s1_uu_ff, s1_ut_ff, s1_tt_ff;
   logic [16:0] s1_u_in;
   logic [32:0] s1_uu_in, s1_ut_in, s1_tt_in;
   // stage 2: weights
   logic        s2_valid_ff, s2_tag_ff;
   logic [48:0] s2_w_ff  [4];
   logic [32:0] s2_sw_ff [3];
   logic [48:0] s2_w_in  [4];
   logic [32:0] s2_sw_in [3];
   // stage 3: products
   logic               s3_valid_ff, s3_tag_ff;
   logic signed [57:0] s3_ph_ff [4][2];
   logic signed [56:0] s3_pl_ff [4][2];
   logic signed [66:0] s3_sp_ff [3][2];
   logic signed [57:0] s3_ph_in [4][2];
   logic signed [56:0] s3_pl_in [4][2];
   logic signed [66:0] s3_sp_in [3][2];
   // stage 4: sums
   logic               s4_valid_ff, s4_tag_ff;
   logic signed [59:0] s4_hs_ff [2];
   logic signed [58:0] s4_ls_ff [2];
   logic signed [68:0] s4_ss_ff [2];
   logic signed [59:0] s4_hs_in [2];
   logic signed [58:0] s4_ls_in [2];
   logic signed [68:0] s4_ss_in [2];

   logic [49:0] uut, utt;
   logic signed [80:0] pt_full [2];
   logic signed [70:0] sl_full [2];

   always_comb begin
      s1_u_in  = 17'(T_ONE) - s0_t_ff;
      s1_uu_in = 33'(34'(s1_u_in) * 34'(s1_u_in));
      s1_ut_in = 33'(34'(s1_u_in) * 34'(s0_t_ff));
      s1_tt_in = 33'(34'(s0_t_ff) * 34'(s0_t_ff));
   end

   always_comb begin
      uut = 50'(s1_uu_ff) * 50'(s1_t_ff);
      utt = 50'(s1_tt_ff) * 50'(s1_u_ff);
      s2_w_in[0]  = 49'(50'(s1_uu_ff) * 50'(s1_u_ff));
      s2_w_in[1]  = 49'(uut + (uut << 1));
      s2_w_in[2]  = 49'(utt + (utt << 1));
      s2_w_in[3]  = 49'(50'(s1_tt_ff) * 50'(s1_t_ff));
      s2_sw_in[0] = s1_uu_ff;
      s2_sw_in[1] = 33'(s1_ut_ff << 1);
      s2_sw_in[2] = s1_tt_ff;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int c = 0; c < 2; c++) begin
            s3_ph_in[k][c] = 58'(coord[2*k+c]) * 58'(signed'({1'b0, s2_w_ff[k][48:24]}));
            s3_pl_in[k][c] = 57'(coord[2*k+c]) * 57'(signed'({1'b0, s2_w_ff[k][23:0]}));
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 2; c++) begin
            s3_sp_in[k][c] = 67'(33'(coord[2*k+2+c]) - 33'(coord[2*k+c]))
                           * 67'(signed'({1'b0, s2_sw_ff[k]}));
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         s4_hs_in[c] = 60'(s3_ph_ff[0][c]) + 60'(s3_ph_ff[1][c])
                     + 60'(s3_ph_ff[2][c]) + 60'(s3_ph_ff[3][c]);
         s4_ls_in[c] = 59'(s3_pl_ff[0][c]) + 59'(s3_pl_ff[1][c])
                     + 59'(s3_pl_ff[2][c]) + 59'(s3_pl_ff[3][c]);
         s4_ss_in[c] = 69'(s3_sp_ff[0][c]) + 69'(s3_sp_ff[1][c]) + 69'(s3_sp_ff[2][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_tag_ff <= in_tag;
         s0_t_ff   <= in_t;
         s1_tag_ff <= s0_tag_ff;
         s1_u_ff   <= s1_u_in;
         s1_t_ff   <= s0_t_ff;
         s1_uu_ff  <= s1_uu_in;
         s1_ut_ff  <= s1_ut_in;
         s1_tt_ff  <= s1_tt_in;
         s2_tag_ff <= s1_tag_ff;
         s2_w_ff   <= s2_w_in;
         s2_sw_ff  <= s2_sw_in;
         s3_tag_ff <= s2_tag_ff;
         s3_ph_ff  <= s3_ph_in;
         s3_pl_ff  <= s3_pl_in;
         s3_sp_ff  <= s3_sp_in;
         s4_tag_ff <= s3_tag_ff;
         s4_hs_ff  <= s4_hs_in;
         s4_ls_ff  <= s4_ls_in;
         s4_ss_ff  <= s4_ss_in;
      end
   end

   // round to nearest, ties upward
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         pt_full[c] = (81'(s4_hs_ff[c]) <<< 24) + 81'(s4_ls_ff[c]) + (81'sd1 <<< 47);
         sl_full[c] = 71'(s4_ss_ff[c]) + (71'(s4_ss_ff[c]) <<< 1) + (71'sd1 <<< 31);
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_tag   = s4_tag_ff;
   assign out_x     = pt_full[0][79:48];
   assign out_y     = pt_full[1][79:48];
   assign out_sx    = sl_full[0][67:32];
   assign out_sy    = sl_full[1][67:32];

endmodule

// ----- rtl/cbe_len_unit.sv -----
// Arc length sequencer: issues samples, square root per segment, accumulates.
module cbe_len_unit #(
   parameter int LENGTH_SAMPLES = cbe_pkg::LENGTH_SAMPLES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  en,
   input  cbe_pkg::coord_type    start_x,
   input  cbe_pkg::coord_type    start_y,
   input  cbe_pkg::sample_type   sample,
   output cbe_pkg::issue_type    issue,
   output logic                  busy,
   output logic                  done,
   input  logic                  ack,
   output logic [37:0]           length
);
   import cbe_pkg::*;

   localparam int IDX_W      = $clog2(LENGTH_SAMPLES + 1);
   localparam int T_STEP     = T_ONE / LENGTH_SAMPLES;
   localparam int T_REM      = T_ONE % LENGTH_SAMPLES;
   localparam int ROOT_STEPS = 33;

   len_state_type state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [16:0]       t_ff;
   logic [IDX_W-1:0]  rem_ff;
   coord_type         px_ff, py_ff;
   logic [32:0]       ax_ff, ay_ff;
   logic [65:0]       a2_ff, b2_ff;
   logic [65:0]       q_ff, res_ff, bit_ff;
   logic [5:0]        iter_ff;
   logic [38:0]       total_ff;

   logic signed [32:0] dx, dy;
   logic [65:0]        trial;
   logic [IDX_W:0]     rem_sum;
   logic               last;

   assign last    = (idx_ff == IDX_W'(LENGTH_SAMPLES));
   assign dx      = 33'(sample.x) - 33'(px_ff);
   assign dy      = 33'(sample.y) - 33'(py_ff);
   assign trial   = res_ff + bit_ff;
   assign rem_sum = (IDX_W + 1)'(rem_ff) + (IDX_W + 1)'(T_REM);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LEN_IDLE:   if (start) state_in = LEN_ISSUE;
         LEN_ISSUE:  if (en) state_in = LEN_WAIT;
         LEN_WAIT:   if (sample.valid) state_in = LEN_SQUARE;
         LEN_SQUARE: state_in = LEN_SUM;
         LEN_SUM:    state_in = LEN_ROOT;
         LEN_ROOT:   if (iter_ff == 6'(ROOT_STEPS - 1)) state_in = LEN_ACCUM;
         LEN_ACCUM:  state_in = last ? LEN_DONE : LEN_ISSUE;
         LEN_DONE:   if (ack) state_in = LEN_IDLE;
         default:    state_in = LEN_IDLE;
      endcase
   end

   always_comb begin
      issue.valid = (state_ff == LEN_ISSUE);
      issue.t     = last ? 17'(T_ONE) : t_ff;
      busy        = (state_ff != LEN_IDLE);
      done        = (state_ff == LEN_DONE);
      length      = total_ff[38] ? {38{1'b1}} : total_ff[37:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LEN_IDLE: begin
            idx_ff   <= IDX_W'(1);
            t_ff     <= 17'(T_STEP);
            rem_ff   <= IDX_W'(T_REM);
            px_ff    <= start_x;
            py_ff    <= start_y;
            total_ff <= '0;
         end
         LEN_WAIT: begin
            if (sample.valid) begin
               ax_ff <= dx[32] ? 33'(-dx) : 33'(dx);
               ay_ff <= dy[32] ? 33'(-dy) : 33'(dy);
               px_ff <= sample.x;
               py_ff <= sample.y;
            end
         end
         LEN_SQUARE: begin
            a2_ff <= 66'(ax_ff) * 66'(ax_ff);
            b2_ff <= 66'(ay_ff) * 66'(ay_ff);
         end
         LEN_SUM: begin
            q_ff    <= a2_ff + b2_ff;
            res_ff  <= '0;
            bit_ff  <= 66'(1) << 64;
            iter_ff <= '0;
         end
         LEN_ROOT: begin
            if (q_ff >= trial) begin
               q_ff   <= q_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            iter_ff <= iter_ff + 6'd1;
         end
         LEN_ACCUM: begin
            total_ff <= total_ff + 39'(res_ff);
            idx_ff   <= idx_ff + IDX_W'(1);
            if (rem_sum >= (IDX_W + 1)'(LENGTH_SAMPLES)) begin
               rem_ff <= IDX_W'(rem_sum - (IDX_W + 1)'(LENGTH_SAMPLES));
               t_ff   <= t_ff + 17'(T_STEP) + 17'd1;
            end else begin
               rem_ff <= IDX_W'(rem_sum);
               t_ff   <= t_ff + 17'(T_STEP);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/cubic_bezier_evaluator_core.sv -----
// Top level of the cubic Bezier evaluator: registers, pipeline, length unit, output stage.
// Usage:
//  - csr_*: write the eight curve coordinates (Q16.16) while the block is idle;
//    csr_ready is always high, index 0..7 is start, ctrl a, ctrl b, end (x then y).
//  - req_*: one transaction per cycle while req_stall is low; action 0 evaluates point and slope at t_param,
//    action 1 computes the polyline arc length.
//  - rsp_*: one result transaction per request, in request order.
// An evaluate transaction passes through the five-stage multiply/sum pipeline (first
// stage loaded at acceptance) and then the output register; one per cycle while the
// output is not stalled.
// In a length transaction each sample runs through the point pipeline, then a 33-step
// square root; req_stall is held high until its result is delivered.
// Reset clears all valid bits, the length sequencer and the coordinate registers.
// When rsp_stall is high while rsp_valid is set, the output register holds and the whole
// pipeline freezes, so req_stall rises as well; nothing is dropped or repeated.
module cubic_bezier_evaluator_core #(
   parameter int LENGTH_SAMPLES = cbe_pkg::LENGTH_SAMPLES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cbe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cbe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                         csr_data
);
   import cbe_pkg::*;

   coord_type  coord_ff [NUM_REGS];
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   logic       en, req_take, len_busy, len_done;
   logic       pipe_in_valid, pipe_in_tag;
   logic [16:0] pipe_in_t, t_clamped;
   logic       pipe_valid, pipe_tag;
   logic signed [31:0] pipe_x, pipe_y;
   logic signed [35:0] pipe_sx, pipe_sy;
   logic [37:0] len_value;
   issue_type  issue;
   sample_type sample;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) coord_ff[i] <= '0;
      end else if (csr_valid) begin
         coord_ff[csr_index] <= signed'(csr_data);
      end
   end

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = len_busy || !en;
   assign req_take  = req_valid && !req_stall;
   assign t_clamped = (req_data.t_param > 17'(T_ONE)) ? 17'(T_ONE) : req_data.t_param;

   always_comb begin
      pipe_in_valid = (req_take && req_data.action == ACTION_EVAL) || issue.valid;
      pipe_in_tag   = issue.valid;
      pipe_in_t     = issue.valid ? issue.t : t_clamped;
   end

   cbe_point_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_in_valid),
      .in_tag    (pipe_in_tag),
      .in_t      (pipe_in_t),
      .coord     (coord_ff),
      .out_valid (pipe_valid),
      .out_tag   (pipe_tag),
      .out_x     (pipe_x),
      .out_y     (pipe_y),
      .out_sx    (pipe_sx),
      .out_sy    (pipe_sy)
   );

   always_comb begin
      sample.valid = pipe_valid && pipe_tag && en;
      sample.x     = pipe_x;
      sample.y     = pipe_y;
   end

   cbe_len_unit #(
      .LENGTH_SAMPLES (LENGTH_SAMPLES)
   ) u_len (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take && req_data.action == ACTION_LENGTH),
      .en      (en),
      .start_x (coord_ff[REG_START_X]),
      .start_y (coord_ff[REG_START_Y]),
      .sample  (sample),
      .issue   (issue),
      .busy    (len_busy),
      .done    (len_done),
      .ack     (len_done && en),
      .length  (len_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= (pipe_valid && !pipe_tag) || len_done;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (len_done) begin
            rsp_data_ff.point_x    <= '0;
            rsp_data_ff.point_y    <= '0;
            rsp_data_ff.slope_x    <= '0;
            rsp_data_ff.slope_y    <= '0;
            rsp_data_ff.arc_length <= len_value;
         end else begin
            rsp_data_ff.point_x    <= pipe_x;
            rsp_data_ff.point_y    <= pipe_y;
            rsp_data_ff.slope_x    <= pipe_sx;
            rsp_data_ff.slope_y    <= pipe_sy;
            rsp_data_ff.arc_length <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/cbe_checker.sv -----
// Checker for the cubic Bezier evaluator: tracks curve registers, predicts and compares results.
module cbe_checker
   import cbe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef logic signed [127:0] wide_type;

   coord_type curve_reg [NUM_REGS];
   rsp_type   expected_rsp [$];

   function automatic wide_type coord_of(int idx);
      wide_type v;
      v = curve_reg[idx];
      return v;
   endfunction

   function automatic logic signed [31:0] curve_point(int axis, logic [16:0] t);
      wide_type u, tt, w [4], acc;
      u     = T_ONE - t;
      tt    = t;
      w[0]  = u * u * u;
      w[1]  = 3 * u * u * tt;
      w[2]  = 3 * u * tt * tt;
      w[3]  = tt * tt * tt;
      acc   = 0;
      for (int k = 0; k < 4; k++) acc += coord_of(2 * k + axis) * w[k];
      acc = (acc + (wide_type'(1) <<< 47)) >>> 48;
      return acc[31:0];
   endfunction

   function automatic logic signed [35:0] curve_slope(int axis, logic [16:0] t);
      wide_type u, tt, w [3], acc;
      u    = T_ONE - t;
      tt   = t;
      w[0] = u * u;
      w[1] = 2 * u * tt;
      w[2] = tt * tt;
      acc  = 0;
      for (int k = 0; k < 3; k++)
         acc += (coord_of(2 * (k + 1) + axis) - coord_of(2 * k + axis)) * w[k];
      acc = (3 * acc + (wide_type'(1) <<< 31)) >>> 32;
      return acc[35:0];
   endfunction

   function automatic wide_type int_sqrt(wide_type q);
      wide_type res, bit_val;
      res     = 0;
      bit_val = wide_type'(1) <<< 124;
      while (bit_val > q) bit_val = bit_val >>> 2;
      while (bit_val != 0) begin
         if (q >= res + bit_val) begin
            q   = q - (res + bit_val);
            res = (res >>> 1) + bit_val;
         end else begin
            res = res >>> 1;
         end
         bit_val = bit_val >>> 2;
      end
      return res;
   endfunction

   function automatic logic [37:0] polyline_length();
      wide_type px, py, x, y, total;
      logic [16:0] t;
      px    = coord_of(REG_START_X);
      py    = coord_of(REG_START_Y);
      total = 0;
      for (int i = 1; i <= LENGTH_SAMPLES_DEFAULT; i++) begin
         t = (i == LENGTH_SAMPLES_DEFAULT) ? 17'(T_ONE) : 17'((i * T_ONE) / LENGTH_SAMPLES_DEFAULT);
         x = curve_point(0, t);
         y = curve_point(1, t);
         total += int_sqrt((x - px) * (x - px) + (y - py) * (y - py));
         px = x;
         py = y;
      end
      if (total > ((wide_type'(1) <<< 38) - 1)) total = (wide_type'(1) <<< 38) - 1;
      return total[37:0];
   endfunction

   function automatic rsp_type predict_result(req_type rq);
      rsp_type     r;
      logic [16:0] t;
      r = '0;
      t = (rq.t_param > T_ONE) ? 17'(T_ONE) : rq.t_param;
      if (rq.action == ACTION_EVAL) begin
         r.point_x = curve_point(0, t);
         r.point_y = curve_point(1, t);
         r.slope_x = curve_slope(0, t);
         r.slope_y = curve_slope(1, t);
      end else begin
         r.arc_length = polyline_length();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) curve_reg[k] = '0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) curve_reg[csr_index] = csr_data;
         if (req_valid && !req_stall) expected_rsp.push_back(predict_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected transaction: %p", rsp_data);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (exp_r.point_x !== rsp_data.point_x || exp_r.point_y !== rsp_data.point_y
                   || exp_r.slope_x !== rsp_data.slope_x || exp_r.slope_y !== rsp_data.slope_y
                   || exp_r.arc_length !== rsp_data.arc_length) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p actual %p", exp_r, rsp_data);
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the cubic Bezier evaluator: clock, reset, stimulus and verdict.
module tb_top;
   import cbe_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_data = '0;
   int                         fail_count;
   int                         pending;

   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_tokens = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int cycles      = 0;

   cubic_bezier_evaluator_core i_dut (.*);

   cbe_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stall plus one long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_tokens) begin
         hold_seen = hold_tokens;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_req(logic action, logic [16:0] t);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data.action  <= action;
      req_data.t_param <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(2097151)) - 1048576);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
      endcase
   endfunction

   task automatic load_curve(int mode);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (10) @(negedge clock);
      write_reg(REG_START_X, pick_coord(mode));
      write_reg(REG_START_Y, pick_coord(mode));
      write_reg(REG_CTRL_A_X, pick_coord(mode));
      write_reg(REG_CTRL_A_Y, pick_coord(mode));
      write_reg(REG_CTRL_B_X, pick_coord(mode));
      write_reg(REG_CTRL_B_Y, pick_coord(mode));
      write_reg(REG_END_X, pick_coord(mode));
      write_reg(REG_END_Y, pick_coord(mode));
   endtask

   task automatic send_random(int count);
      logic [16:0] t;
      for (int n = 0; n < count; n++) begin
         t = ($urandom_range(9) == 0) ? 17'($urandom()) : 17'($urandom_range(T_ONE));
         send_req(($urandom_range(49) == 0) ? ACTION_LENGTH : ACTION_EVAL, t);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of t, beyond one, length on extreme curves
      for (int mode = 2; mode <= 3; mode++) begin
         load_curve(mode);
         send_req(ACTION_EVAL, 17'd0);
         send_req(ACTION_EVAL, 17'd65536);
         send_req(ACTION_EVAL, 17'd65535);
         send_req(ACTION_EVAL, 17'd1);
         send_req(ACTION_EVAL, 17'd32768);
         send_req(ACTION_EVAL, 17'h1FFFF);
         send_req(ACTION_LENGTH, 17'h1FFFF);
         send_req(ACTION_LENGTH, 17'd0);
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         load_curve(phase % 4);
         if (phase == 3) hold_tokens++;
         send_random(90);
         @(negedge clock);
         req_valid <= 1'b0;
         wait (pending == 0);
         send_random(90);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cbe_pkg.sv
rtl/cbe_point_pipe.sv
rtl/cbe_len_unit.sv
rtl/cubic_bezier_evaluator_core.sv
tb/cbe_checker.sv
tb/tb_top.sv
